// ===== hdl/tkis_pkg.sv =====
// shared types and constants for the top-k index selector
package tkis_pkg;

  localparam int SCORE_W = 32;
  localparam int KEEP_W  = 5;
  localparam int INDEX_W = 10;

  localparam logic [KEEP_W-1:0] KEEP_RESET = 5'd4;

  // commands from controller to datapath
  typedef struct packed {
    logic ins;       // take the input item into the cell row
    logic load_rem;  // load the report counter with min(k, held)
    logic emit;      // move the head entry to the output register, shift row up
    logic clr;       // clear set counters and overflow mark
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic n_zero;    // nothing to report for this set
    logic rem_one;   // one index left to report
    logic rem_zero;  // report counter empty
  } status_t;

endpackage

// ===== hdl/tkis_ctrl.sv =====
// controller state machine for the top-k index selector
module tkis_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             last_score,
  input  logic             out_ready,
  input  tkis_pkg::status_t st,
  output logic             in_ready,
  output logic             out_valid,
  output tkis_pkg::cmd_t   cmd
);

  typedef enum logic [2:0] {
    ST_COLLECT = 3'b001,
    ST_LOAD    = 3'b010,
    ST_EMIT    = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   out_free;

  // output register can take a new item
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_COLLECT);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_COLLECT: begin
        if (in_valid) begin
          cmd.ins = 1'b1;
          if (last_score) begin
            state_next = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        cmd.load_rem = 1'b1;
        if (st.n_zero) begin
          cmd.clr    = 1'b1;
          state_next = ST_COLLECT;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.emit = 1'b1;
          if (st.rem_one) begin
            cmd.clr    = 1'b1;
            state_next = ST_COLLECT;
          end
        end
      end
      default: begin
        state_next = ST_COLLECT;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_COLLECT;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== hdl/tkis_dp.sv =====
// datapath: insertion cell row, set counters, k register and output register
module tkis_dp #(
  parameter int MAX_K     = 16,
  parameter int MAX_ITEMS = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [tkis_pkg::KEEP_W-1:0]           cfg_data,
  input  logic signed [tkis_pkg::SCORE_W-1:0]   score,
  input  tkis_pkg::cmd_t                        cmd,
  output tkis_pkg::status_t                     st,
  output logic [tkis_pkg::INDEX_W-1:0]          index,
  output logic                                  last_index,
  output logic                                  overflow
);

  localparam int CNT_W = $clog2(MAX_K + 1);
  localparam int AW    = $clog2(MAX_ITEMS + 1);
  localparam int IDX_W = $clog2(MAX_ITEMS);
  localparam int CW    = (CNT_W > tkis_pkg::KEEP_W) ? CNT_W : tkis_pkg::KEEP_W;

  logic [tkis_pkg::KEEP_W-1:0] keep_count;
  logic [CNT_W-1:0]            held;
  logic [AW-1:0]               arrival;
  logic                        ovf_seen;
  logic [CNT_W-1:0]            rem;

  logic signed [tkis_pkg::SCORE_W-1:0] score_q [MAX_K];
  logic [IDX_W-1:0]                    idx_q   [MAX_K];

  logic [MAX_K-1:0] ge;
  logic [MAX_K-1:0] take_new;
  logic             room;
  logic             do_ins;
  logic [IDX_W-1:0] new_idx;

  logic [CW-1:0]    k_ext;
  logic [CW-1:0]    k_eff;
  logic [CW-1:0]    held_ext;
  logic [CW-1:0]    n_w;

  // capacity check and arrival number of the incoming item
  assign room    = (arrival < AW'(MAX_ITEMS));
  assign do_ins  = cmd.ins && room;
  assign new_idx = arrival[IDX_W-1:0];

  // report length: min(k, MAX_K, held)
  assign k_ext    = CW'(keep_count);
  assign k_eff    = (k_ext > CW'(MAX_K)) ? CW'(MAX_K) : k_ext;
  assign held_ext = CW'(held);
  assign n_w      = (k_eff < held_ext) ? k_eff : held_ext;

  assign st.n_zero   = (n_w == '0);
  assign st.rem_one  = (rem == CNT_W'(1));
  assign st.rem_zero = (rem == '0);

  // k register, set counters, report counter
  always_ff @(posedge clk) begin
    if (rst) begin
      keep_count <= tkis_pkg::KEEP_RESET;
      held       <= '0;
      arrival    <= '0;
      ovf_seen   <= 1'b0;
      rem        <= '0;
    end else begin
      if (cfg_we) begin
        keep_count <= cfg_data;
      end
      if (cmd.clr) begin
        held     <= '0;
        arrival  <= '0;
        ovf_seen <= 1'b0;
      end else if (cmd.ins) begin
        if (room) begin
          arrival <= arrival + AW'(1);
          if (held < CNT_W'(MAX_K)) begin
            held <= held + CNT_W'(1);
          end
        end else begin
          ovf_seen <= 1'b1;
        end
      end
      if (cmd.load_rem) begin
        rem <= n_w[CNT_W-1:0];
      end else if (cmd.emit) begin
        rem <= rem - CNT_W'(1);
      end
    end
  end

  // row of insertion cells, sorted best first, earlier index first on ties
  for (genvar i = 0; i < MAX_K; i++) begin : g_cell
    logic signed [tkis_pkg::SCORE_W-1:0] prev_score;
    logic [IDX_W-1:0]                    prev_idx;
    logic signed [tkis_pkg::SCORE_W-1:0] nxt_score;
    logic [IDX_W-1:0]                    nxt_idx;

    // held entry stays ahead of the new item
    assign ge[i] = (CNT_W'(i) < held) && (score_q[i] >= score);

    if (i == 0) begin : g_head
      assign take_new[i] = !ge[i];
      assign prev_score  = score;
      assign prev_idx    = new_idx;
    end else begin : g_body
      assign take_new[i] = !ge[i] && ge[i-1];
      assign prev_score  = score_q[i-1];
      assign prev_idx    = idx_q[i-1];
    end

    if (i == MAX_K - 1) begin : g_tail
      assign nxt_score = score_q[i];
      assign nxt_idx   = idx_q[i];
    end else begin : g_inner
      assign nxt_score = score_q[i+1];
      assign nxt_idx   = idx_q[i+1];
    end

    // insert shifts down, readout shifts up
    always_ff @(posedge clk) begin
      if (do_ins) begin
        if (take_new[i]) begin
          score_q[i] <= score;
          idx_q[i]   <= new_idx;
        end else if (!ge[i]) begin
          score_q[i] <= prev_score;
          idx_q[i]   <= prev_idx;
        end
      end else if (cmd.emit) begin
        score_q[i] <= nxt_score;
        idx_q[i]   <= nxt_idx;
      end
    end
  end

  // output register fed from the head cell
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      index      <= tkis_pkg::INDEX_W'(idx_q[0]);
      last_index <= st.rem_one;
      overflow   <= ovf_seen;
    end
  end

endmodule

// ===== hdl/top_k_index_select.sv =====
// top level of the top-k index selector
//
// Scores arrive on the in_valid/in_ready channel, one item per cycle, each
// numbered by its position in the set. last_score closes the set. A row of
// insertion cells keeps the MAX_K best scores sorted, so collection runs at
// one score per cycle with no stall.
// After the closing score the block sizes the report in its load state, then
// sends min(k, held) indices best first on out_valid/out_ready, one per cycle
// while the receiver takes them; last_index marks the final one, overflow
// tells that scores past MAX_ITEMS were dropped. The first index passes from
// the head cell into the output register in the emit state that follows the
// load state; in_ready is low during the report phase.
// When out_ready is low the output register holds and the report pauses.
// Once the final index sits in the output register, the next set may start.
// k is written on cfg_we/cfg_data (reset value 4); write it between sets.
// rst clears the set counters, the overflow mark and the output valid flag.
module top_k_index_select #(
  parameter int MAX_K     = 16,
  parameter int MAX_ITEMS = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [tkis_pkg::KEEP_W-1:0]         cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [tkis_pkg::SCORE_W-1:0] score,
  input  logic                                last_score,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [tkis_pkg::INDEX_W-1:0]        index,
  output logic                                last_index,
  output logic                                overflow
);

  tkis_pkg::cmd_t    cmd;
  tkis_pkg::status_t st;

  // sequencing
  tkis_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .last_score (last_score),
    .out_ready  (out_ready),
    .st         (st),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .cmd        (cmd)
  );

  // cell row and counters
  tkis_dp #(
    .MAX_K     (MAX_K),
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .score      (score),
    .cmd        (cmd),
    .st         (st),
    .index      (index),
    .last_index (last_index),
    .overflow   (overflow)
  );

  // a report step never runs on an empty counter
  assert property (@(posedge clk) disable iff (rst) cmd.emit |-> !st.rem_zero)
    else $error("emit with report counter empty");

  // closing score stops intake for the report phase
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && last_score) |=> !in_ready)
    else $error("intake open right after closing score");

  // insert and readout never share a cycle
  assert property (@(posedge clk) disable iff (rst) !(cmd.ins && (cmd.emit || cmd.load_rem)))
    else $error("insert overlaps report");

  // a freshly emitted item is valid on the next cycle
  assert property (@(posedge clk) disable iff (rst) cmd.emit |=> out_valid)
    else $error("emitted item not presented");

endmodule
